[rtl/i2cm_pkg.sv]
`default_nettype none
package i2cm_pkg;

	typedef enum logic [4:0] {
		P_IDLE, P_ST_D1, P_ST_W, P_ST_D2, P_ST_D3, P_ST_D4,
		P_WB_D1, P_WB_W, P_WB_D2, P_WA_D1, P_WA_W, P_WA_D2, P_WA_D3,
		P_RB_D1, P_RB_W, P_RB_D2, P_RA_D1, P_RA_W, P_RA_D2, P_RA_D3,
		P_SP_D1, P_SP_W, P_SP_D2, P_SP_D3
	} phase_t;

	typedef enum logic [2:0] {
		G_START1, G_ADDR1, G_REGHI, G_REGLO, G_START2, G_ADDR2, G_DATA
	} stage_t;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_BEGIN = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	localparam logic [1:0] MODE_WR     = 2'd0;
	localparam logic [1:0] MODE_RD     = 2'd1;
	localparam logic [1:0] MODE_REG_RD = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_IO      = 2'd2;

	localparam logic [1:0] CFG_HALF    = 2'd0;
	localparam logic [1:0] CFG_STRETCH = 2'd1;

	localparam logic [7:0]  HALF_RESET    = 8'd2;
	localparam logic [15:0] STRETCH_RESET = 16'd1000;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_last;
		logic       done;
		logic [1:0] status;
	} res_t;

endpackage
`default_nettype wire

[rtl/i2cm_ram.sv]
`default_nettype none
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                                    clk,
	input  wire                                    we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                        wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/i2cm_core.sv]
`default_nettype none
module i2cm_core #(
	parameter int MAX_BYTES = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               acc,
	input  wire [1:0]         action,
	input  wire [1:0]         mode,
	input  wire [6:0]         slave_addr,
	input  wire [15:0]        reg_addr,
	input  wire [6:0]         length,
	input  wire [7:0]         data_byte,
	input  wire               scl_in,
	input  wire               sda_in,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_index,
	input  wire [15:0]        cfg_data,
	output i2cm_pkg::res_t    res
);
	import i2cm_pkg::*;

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int FW = $clog2(MAX_BYTES + 1);

	phase_t phase_q, phase_d;
	stage_t stage_q, stage_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [6:0]  bi_q, bi_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  dly_q, dly_d;
	logic [15:0] str_q, str_d;
	logic [1:0]  mode_q, mode_d;
	logic [6:0]  dev_q, dev_d;
	logic [15:0] reg_q, reg_d;
	logic [6:0]  len_q, len_d;
	logic [7:0]  half_q;
	logic [15:0] tmo_q;
	logic        ack_q, ack_d, scl_q, scl_d, sda_q, sda_d;
	logic [1:0]  pend_q, pend_d;

	logic          we;
	logic [7:0]    rdata;
	logic [AW-1:0] raddr;
	logic [7:0]    h;

	// Next data byte prefetch: stage is fixed through the ACK half, so the
	// registered read is settled by the time the byte is needed.
	assign raddr = (stage_q == G_DATA) ? AW'(bi_q + 7'd1) : '0;
	assign h     = (half_q == 8'd0) ? 8'd2 : half_q;

	i2cm_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(fill_q)),
		.wdata (data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		logic       cmp, f_dn, f_wr, f_stop, f_start, f_delay, f_wait, f_fin, f_aw, f_to;
		logic [7:0] wb, a;
		stage_t     wg, sg;
		phase_t     dph, wph;
		logic [1:0] scode, fcode;

		phase_d = phase_q; stage_d = stage_q; fill_d = fill_q; bi_d = bi_q;
		bit_d = bit_q; shift_d = shift_q; dly_d = dly_q; str_d = str_q;
		mode_d = mode_q; dev_d = dev_q; reg_d = reg_q; len_d = len_q;
		ack_d = ack_q; scl_d = scl_q; sda_d = sda_q; pend_d = pend_q;
		we = 1'b0;
		res = '0;
		cmp = 1'b0; f_dn = 1'b0; f_wr = 1'b0; f_stop = 1'b0; f_start = 1'b0;
		f_delay = 1'b0; f_wait = 1'b0; f_fin = 1'b0; f_aw = 1'b0; f_to = 1'b0;
		wb = '0; wg = G_DATA; sg = G_START1; dph = P_IDLE; wph = P_IDLE;
		scode = ST_OK; fcode = ST_OK;
		a = {dev_q, 1'b0};

		if (acc) begin
			if (action == ACT_TICK) begin
				unique case (phase_q)
					P_IDLE: ;
					P_ST_W, P_WB_W, P_WA_W, P_RB_W, P_RA_W, P_SP_W: begin
						if (scl_in) begin
							cmp = 1'b1;
						end else begin
							if (str_q != 16'hFFFF) str_d = str_q + 16'd1;
							if (str_d >= tmo_q) f_to = 1'b1;
						end
					end
					default: begin
						dly_d = dly_q + 8'd1;
						if (dly_d >= h) cmp = 1'b1;
					end
				endcase
			end else if (action == ACT_BEGIN && phase_q == P_IDLE) begin
				mode_d = mode; dev_d = slave_addr; reg_d = reg_addr;
				len_d  = (32'(length) > MAX_BYTES) ? 7'(MAX_BYTES) : length;
				fill_d = '0; bi_d = '0; pend_d = ST_OK;
				f_start = 1'b1; sg = G_START1;
			end else if (action == ACT_LOAD && phase_q == P_IDLE
					&& 32'(fill_q) < MAX_BYTES) begin
				we = 1'b1;
				fill_d = fill_q + FW'(1);
			end
		end

		if (f_to) begin
			unique case (phase_q)
				P_ST_W:         begin f_fin = 1'b1; fcode = ST_TIMEOUT; end
				P_WB_W, P_WA_W: begin f_stop = 1'b1; scode = ST_IO; end
				P_RB_W, P_RA_W: begin f_stop = 1'b1; scode = ST_TIMEOUT; end
				default:        begin f_fin = 1'b1; fcode = pend_q; end
			endcase
		end

		if (cmp) begin
			unique case (phase_q)
				P_ST_D1: begin f_wait = 1'b1; wph = P_ST_W; end
				P_ST_W:  begin f_delay = 1'b1; dph = P_ST_D2; end
				P_ST_D2: begin sda_d = 1'b1; f_delay = 1'b1; dph = P_ST_D3; end
				P_ST_D3: begin scl_d = 1'b1; f_delay = 1'b1; dph = P_ST_D4; end
				P_ST_D4: begin
					f_wr = 1'b1;
					if (stage_q == G_START1) begin
						wb = (mode_q == MODE_RD) ? (a | 8'h01) : a;
						wg = G_ADDR1;
					end else begin
						wb = a | 8'h01;
						wg = G_ADDR2;
					end
				end
				P_WB_D1: begin f_wait = 1'b1; wph = P_WB_W; end
				P_WB_W:  begin f_delay = 1'b1; dph = P_WB_D2; end
				P_WB_D2: begin
					scl_d = 1'b1;
					bit_d = bit_q + 4'd1;
					f_delay = 1'b1;
					if (bit_d < 4'd8) begin
						sda_d = ~shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						dph = P_WB_D1;
					end else begin
						sda_d = 1'b0;
						dph = P_WA_D1;
					end
				end
				P_WA_D1: begin f_wait = 1'b1; wph = P_WA_W; end
				P_WA_W:  begin f_delay = 1'b1; dph = P_WA_D2; end
				P_WA_D2: begin
					ack_d = ~sda_in; scl_d = 1'b1; f_delay = 1'b1; dph = P_WA_D3;
				end
				P_WA_D3: begin
					if (ack_q) f_aw = 1'b1;
					else begin f_stop = 1'b1; scode = ST_IO; end
				end
				P_RB_D1: begin f_wait = 1'b1; wph = P_RB_W; end
				P_RB_W:  begin f_delay = 1'b1; dph = P_RB_D2; end
				P_RB_D2: begin
					shift_d = {shift_q[6:0], sda_in};
					scl_d = 1'b1;
					bit_d = bit_q + 4'd1;
					f_delay = 1'b1;
					if (bit_d < 4'd8) dph = P_RB_D1;
					else begin
						sda_d = ({1'b0, bi_q} + 8'd1) < {1'b0, len_q};
						dph = P_RA_D1;
					end
				end
				P_RA_D1: begin f_wait = 1'b1; wph = P_RA_W; end
				P_RA_W:  begin f_delay = 1'b1; dph = P_RA_D2; end
				P_RA_D2: begin scl_d = 1'b1; f_delay = 1'b1; dph = P_RA_D3; end
				P_RA_D3: begin
					sda_d = 1'b0;
					res.rx_valid = 1'b1;
					res.rx_byte  = shift_q;
					res.rx_last  = ({1'b0, bi_q} + 8'd1) >= {1'b0, len_q};
					bi_d = bi_q + 7'd1;
					f_dn = 1'b1;
				end
				P_SP_D1: begin f_wait = 1'b1; wph = P_SP_W; end
				P_SP_W:  begin f_delay = 1'b1; dph = P_SP_D2; end
				P_SP_D2: begin sda_d = 1'b0; f_delay = 1'b1; dph = P_SP_D3; end
				P_SP_D3: begin f_fin = 1'b1; fcode = pend_q; end
				default: phase_d = P_IDLE;
			endcase
		end

		if (f_aw) begin
			unique case (stage_q)
				G_ADDR1: begin
					if (mode_q[1]) begin f_wr = 1'b1; wb = reg_q[15:8]; wg = G_REGHI; end
					else begin bi_d = '0; f_dn = 1'b1; end
				end
				G_REGHI: begin f_wr = 1'b1; wb = reg_q[7:0]; wg = G_REGLO; end
				G_REGLO: begin
					if (mode_q == MODE_REG_RD) begin f_start = 1'b1; sg = G_START2; end
					else begin bi_d = '0; f_dn = 1'b1; end
				end
				G_ADDR2: begin bi_d = '0; f_dn = 1'b1; end
				default: begin bi_d = bi_q + 7'd1; f_dn = 1'b1; end
			endcase
		end

		if (f_dn) begin
			if (bi_d >= len_q) begin
				f_stop = 1'b1; scode = ST_OK;
			end else if (mode_q[0]) begin
				sda_d = 1'b0; shift_d = '0; bit_d = '0; stage_d = G_DATA;
				f_delay = 1'b1; dph = P_RB_D1;
			end else begin
				f_wr = 1'b1; wb = rdata; wg = G_DATA;
			end
		end

		if (f_wr) begin
			stage_d = wg; bit_d = '0; sda_d = ~wb[7];
			shift_d = {wb[6:0], 1'b0};
			f_delay = 1'b1; dph = P_WB_D1;
		end
		if (f_stop) begin
			pend_d = scode; sda_d = 1'b1; f_delay = 1'b1; dph = P_SP_D1;
		end
		if (f_start) begin
			sda_d = 1'b0; stage_d = sg; f_delay = 1'b1; dph = P_ST_D1;
		end
		if (f_delay) begin
			phase_d = dph; dly_d = '0;
		end
		if (f_wait) begin
			scl_d = 1'b0; phase_d = wph; str_d = '0;
		end
		if (f_fin) begin
			phase_d = P_IDLE; res.done = 1'b1; res.status = fcode;
		end

		res.scl_low = scl_d;
		res.sda_low = sda_d;
		res.busy    = (phase_d != P_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; stage_q <= G_START1; fill_q <= '0; bi_q <= '0;
			bit_q <= '0; shift_q <= '0; dly_q <= '0; str_q <= '0;
			mode_q <= '0; dev_q <= '0; reg_q <= '0; len_q <= '0;
			ack_q <= 1'b0; scl_q <= 1'b0; sda_q <= 1'b0; pend_q <= ST_OK;
			half_q <= HALF_RESET; tmo_q <= STRETCH_RESET;
		end else begin
			phase_q <= phase_d; stage_q <= stage_d; fill_q <= fill_d; bi_q <= bi_d;
			bit_q <= bit_d; shift_q <= shift_d; dly_q <= dly_d; str_q <= str_d;
			mode_q <= mode_d; dev_q <= dev_d; reg_q <= reg_d; len_q <= len_d;
			ack_q <= ack_d; scl_q <= scl_d; sda_q <= sda_d; pend_q <= pend_d;
			if (cfg_we && cfg_index == CFG_HALF) half_q <= cfg_data[7:0];
			if (cfg_we && cfg_index == CFG_STRETCH) tmo_q <= cfg_data;
		end
	end
endmodule
`default_nettype wire

[rtl/i2cm_outbuf.sv]
`default_nettype none
module i2cm_outbuf (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  i2cm_pkg::res_t din,
	output logic           full,
	output logic           out_valid,
	input  wire            out_stall,
	output i2cm_pkg::res_t dout
);
	import i2cm_pkg::*;

	logic ov_q, sv_q, pop;
	res_t od_q, sd_q;

	assign pop       = ov_q && !out_stall;
	assign full      = sv_q;
	assign out_valid = ov_q;
	assign dout      = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (pop) begin
			if (sv_q) begin
				sv_q <= 1'b0;
			end else begin
				ov_q <= push;
			end
		end else if (push) begin
			if (!ov_q) ov_q <= 1'b1;
			else sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) od_q <= sd_q;
			else od_q <= din;
		end else if (push) begin
			if (!ov_q) od_q <= din;
			else sd_q <= din;
		end
	end
endmodule
`default_nettype wire

[rtl/i2c_master_transaction_engine.sv]
`default_nettype none
// Open-drain I2C master. Load write bytes (action 2), then begin (action 1) a
// plain write, plain read, register write or register read with repeated
// START; tick beats (action 0) carry the sampled SCL/SDA and step the bus time
// base. Every accepted beat yields exactly one result beat holding the line
// drives, busy, any received byte and any completion status. One beat is taken
// per clock unless stalled: the state update is a single step and a two-entry
// output skid lets input continue while one result waits. Write data lives in
// a MAX_BYTES x 8 RAM with registered read; the next data byte is prefetched
// during the ACK half of the previous byte. The buffer needs no clearing after
// reset. Config (index 0 half period ticks, 1 stretch timeout) is for the user
// to write only while idle (not enforced); cfg_ready is always high.
module i2c_master_transaction_engine #(
	parameter int MAX_BYTES = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [1:0]  action,
	input  wire [1:0]  mode,
	input  wire [6:0]  slave_addr,
	input  wire [15:0] reg_addr,
	input  wire [6:0]  length,
	input  wire [7:0]  data_byte,
	input  wire        scl_in,
	input  wire        sda_in,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       scl_low,
	output logic       sda_low,
	output logic       busy_res,
	output logic       rx_valid,
	output logic [7:0] rx_byte,
	output logic       rx_last,
	output logic       done_res,
	output logic [1:0] status,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data
);
	import i2cm_pkg::*;

	logic acc, full;
	res_t res, ores;

	assign in_stall  = full;
	assign acc       = in_valid && !full;
	assign cfg_ready = 1'b1;

	i2cm_core #(.MAX_BYTES(MAX_BYTES)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.action     (action),
		.mode       (mode),
		.slave_addr (slave_addr),
		.reg_addr   (reg_addr),
		.length     (length),
		.data_byte  (data_byte),
		.scl_in     (scl_in),
		.sda_in     (sda_in),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res)
	);

	i2cm_outbuf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.din       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (ores)
	);

	assign scl_low  = ores.scl_low;
	assign sda_low  = ores.sda_low;
	assign busy_res = ores.busy;
	assign rx_valid = ores.rx_valid;
	assign rx_byte  = ores.rx_byte;
	assign rx_last  = ores.rx_last;
	assign done_res = ores.done;
	assign status   = ores.status;
endmodule
`default_nettype wire

[rtl/i2cm_checker.sv]
`default_nettype none
module i2cm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_stall,
	input wire       busy_res,
	input wire       rx_valid,
	input wire [7:0] rx_byte,
	input wire       rx_last,
	input wire       done_res,
	input wire [1:0] status
);
	import i2cm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(rx_byte))
		else $error("stalled result changed");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while busy");
	a_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> busy_res && !done_res)
		else $error("byte received outside a transaction");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK)
		else $error("status without done");
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_byte == 8'd0 && !rx_last)
		else $error("stray receive data");
endmodule

bind i2c_master_transaction_engine i2cm_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.busy_res  (busy_res),
	.rx_valid  (rx_valid),
	.rx_byte   (rx_byte),
	.rx_last   (rx_last),
	.done_res  (done_res),
	.status    (status)
);
`default_nettype wire
